### rtl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
package bsc_pkg;

   // Datapath word width and register index width.
   localparam int unsigned WORD_W = 32;
   localparam int unsigned CSR_IDX_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_AC1 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AC2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_AC3 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_AC4 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AC5 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AC6 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_B1_B2 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MC_MD = 3'd7;

   // Compensation constants.
   localparam logic [31:0] B6_OFFSET = 32'd4000;
   localparam logic [31:0] X3_BIAS = 32'd32768;
   localparam logic [31:0] P_SCALE = 32'd50000;
   localparam logic [31:0] P_SQ_GAIN = 32'd3038;
   localparam logic [31:0] P_LIN_GAIN = 32'd7357;
   localparam logic [31:0] P_BIAS = 32'd3791;

   // Saturation limits.
   localparam logic signed [31:0] T_MIN = -32'sd32768;
   localparam logic signed [31:0] T_MAX = 32'sd32767;
   localparam logic signed [31:0] P_MIN = -32'sd8388608;
   localparam logic signed [31:0] P_MAX = 32'sd8388607;

   // Calibration words, extended to the datapath width.
   typedef struct packed {
      logic [31:0] ac1;
      logic [31:0] ac2;
      logic [31:0] ac3;
      logic [31:0] ac4;
      logic [31:0] ac5;
      logic [31:0] ac6;
      logic [31:0] b1;
      logic [31:0] b2;
      logic [31:0] mc;
      logic [31:0] md;
   } cal_type;

   // Side data that travels with the temperature division.
   typedef struct packed {
      logic [31:0] x1;
      logic        err;
      logic        neg;
      logic [18:0] up;
      logic [1:0]  oss;
   } tside_type;

   // Side data that travels with the pressure division.
   typedef struct packed {
      logic [31:0] t;
      logic        err;
      logic        big;
   } pside_type;

endpackage

### rtl/bsc_cal_regs.sv
// Calibration register file with sign and zero extension of each word.
module bsc_cal_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [31:0]                         csr_write_data,
   output bsc_pkg::cal_type                    cal
);

   logic [15:0] ac1_ff, ac2_ff, ac3_ff, ac4_ff, ac5_ff, ac6_ff;
   logic [31:0] b1_b2_ff, mc_md_ff;

   // Register writes; reset loads the factory calibration.
   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ff <= 16'd408;
         ac2_ff <= 16'hFFB8;
         ac3_ff <= 16'hC7D1;
         ac4_ff <= 16'd32741;
         ac5_ff <= 16'd32757;
         ac6_ff <= 16'd23153;
         b1_b2_ff <= 32'd405667844;
         mc_md_ff <= 32'd3724086068;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bsc_pkg::REG_AC1: ac1_ff <= csr_write_data[15:0];
            bsc_pkg::REG_AC2: ac2_ff <= csr_write_data[15:0];
            bsc_pkg::REG_AC3: ac3_ff <= csr_write_data[15:0];
            bsc_pkg::REG_AC4: ac4_ff <= csr_write_data[15:0];
            bsc_pkg::REG_AC5: ac5_ff <= csr_write_data[15:0];
            bsc_pkg::REG_AC6: ac6_ff <= csr_write_data[15:0];
            bsc_pkg::REG_B1_B2: b1_b2_ff <= csr_write_data;
            bsc_pkg::REG_MC_MD: mc_md_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Extend each word to the datapath width.
   always_comb begin
      cal.ac1 = {{16{ac1_ff[15]}}, ac1_ff};
      cal.ac2 = {{16{ac2_ff[15]}}, ac2_ff};
      cal.ac3 = {{16{ac3_ff[15]}}, ac3_ff};
      cal.ac4 = {16'd0, ac4_ff};
      cal.ac5 = {16'd0, ac5_ff};
      cal.ac6 = {16'd0, ac6_ff};
      cal.b1 = {{16{b1_b2_ff[31]}}, b1_b2_ff[31:16]};
      cal.b2 = {{16{b1_b2_ff[15]}}, b1_b2_ff[15:0]};
      cal.mc = {{16{mc_md_ff[31]}}, mc_md_ff[31:16]};
      cal.md = {{16{mc_md_ff[15]}}, mc_md_ff[15:0]};
   end

endmodule

### rtl/bsc_udiv_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bsc_udiv_pipe #(
   parameter int unsigned W = 32,
   parameter int unsigned SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [W-1:0]  in_num,
   input  logic [W-1:0]  in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [W-1:0]  out_quo,
   output logic [SW-1:0] out_side
);

   logic          vld_w  [W+1];
   logic [W-1:0]  num_w  [W+1];
   logic [W-1:0]  rem_w  [W+1];
   logic [W-1:0]  den_w  [W+1];
   logic [SW-1:0] side_w [W+1];

   assign vld_w[0] = in_valid;
   assign num_w[0] = in_num;
   assign rem_w[0] = '0;
   assign den_w[0] = in_den;
   assign side_w[0] = in_side;

   // Each stage brings down one numerator bit and shifts in one quotient bit.
   for (genvar s = 0; s < W; s++) begin : g_stage
      logic          vld_ff;
      logic [W-1:0]  num_ff, rem_ff, den_ff;
      logic [SW-1:0] side_ff;
      logic [W:0]    trial;
      logic [W:0]    diff;
      logic          qbit;

      always_comb begin
         trial = {rem_w[s], num_w[s][W-1]};
         diff = trial - {1'b0, den_w[s]};
         qbit = ~diff[W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_w[s];
         end
      end

      always_ff @(posedge clock) begin
         num_ff <= {num_w[s][W-2:0], qbit};
         rem_ff <= qbit ? diff[W-1:0] : trial[W-1:0];
         den_ff <= den_w[s];
         side_ff <= side_w[s];
      end

      assign vld_w[s+1] = vld_ff;
      assign num_w[s+1] = num_ff;
      assign rem_w[s+1] = rem_ff;
      assign den_w[s+1] = den_ff;
      assign side_w[s+1] = side_ff;
   end

   assign out_valid = vld_w[W];
   assign out_quo = num_w[W];
   assign out_side = side_w[W];

endmodule

### rtl/barometric_sensor_compensation.sv
// Top level of the barometric sensor compensation pipeline.
//
//   Channel   Ports                                   Transfer
//   request   start, busy, req_*                      start high and busy low
//   response  rsp_strobe, rsp_*                       one cycle, strobe high
//   config    csr_write_enable, csr_index, csr_*      write enable high
//
// One transaction is taken every cycle while busy is low; each result passes through every
// stage below in order. The depth is set by the two 32-stage pipelined dividers
// (temperature and pressure) plus twelve arithmetic stages.
// Reset is synchronous; busy is high only while reset is held.
// The response side cannot stall, so the pipeline advances every cycle.
module barometric_sensor_compensation (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_raw_temperature,
   input  logic [18:0] req_raw_pressure,
   input  logic [1:0]  req_oversampling,
   output logic        rsp_strobe,
   output logic [15:0] rsp_temperature_decidegrees,
   output logic [23:0] rsp_pressure_pascal,
   output logic        rsp_math_error,
   input  logic        csr_write_enable,
   input  logic [bsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int unsigned LAT = 12 + 2 * bsc_pkg::WORD_W;

   bsc_pkg::cal_type cal;
   logic             accept;

   assign busy = reset;
   assign accept = start && !busy;

   bsc_cal_regs u_cal (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cal              (cal)
   );

   // Valid bits for the arithmetic stages.
   logic s0_vld_ff, sa_vld_ff, sb_vld_ff, sc_vld_ff, sd_vld_ff, se_vld_ff;
   logic sf_vld_ff, sg_vld_ff, sh_vld_ff, si_vld_ff, sj_vld_ff, rsp_vld_ff;
   logic tdiv_vld, pdiv_vld;

   // Stage 0: capture the request.
   logic [15:0] s0_ut_ff;
   logic [18:0] s0_up_ff;
   logic [1:0]  s0_oss_ff;

   always_ff @(posedge clock) begin
      s0_ut_ff <= req_raw_temperature;
      s0_up_ff <= req_raw_pressure;
      s0_oss_ff <= req_oversampling;
   end

   // Stage A: X1 = ((UT - AC6) * AC5) >> 15.
   logic signed [16:0] sa_diff;
   logic signed [33:0] sa_prod;
   logic [31:0] sa_x1_in, sa_x1_ff;
   logic [18:0] sa_up_ff;
   logic [1:0]  sa_oss_ff;

   always_comb begin
      sa_diff = $signed({1'b0, s0_ut_ff}) - $signed({1'b0, cal.ac6[15:0]});
      sa_prod = sa_diff * $signed({1'b0, cal.ac5[15:0]});
      sa_x1_in = 32'($signed(sa_prod[31:0]) >>> 15);
   end

   always_ff @(posedge clock) begin
      sa_x1_ff <= sa_x1_in;
      sa_up_ff <= s0_up_ff;
      sa_oss_ff <= s0_oss_ff;
   end

   // Stage B: divisor X1 + MD, magnitudes and quotient sign.
   logic [31:0] sb_den, sb_num;
   logic [31:0] sb_num_mag_ff, sb_den_mag_ff;
   bsc_pkg::tside_type sb_side_in, sb_side_ff;

   always_comb begin
      sb_den = sa_x1_ff + cal.md;
      sb_num = cal.mc << 11;
      sb_side_in.x1 = sa_x1_ff;
      sb_side_in.err = (sb_den == 32'd0);
      sb_side_in.neg = sb_num[31] ^ sb_den[31];
      sb_side_in.up = sa_up_ff;
      sb_side_in.oss = sa_oss_ff;
   end

   always_ff @(posedge clock) begin
      sb_num_mag_ff <= sb_num[31] ? 32'd0 - sb_num : sb_num;
      sb_den_mag_ff <= sb_den[31] ? 32'd0 - sb_den : sb_den;
      sb_side_ff <= sb_side_in;
   end

   // Temperature divider: X2 = (MC << 11) / (X1 + MD).
   logic [31:0] tdiv_quo;
   logic [$bits(bsc_pkg::tside_type)-1:0] tdiv_side_raw;
   bsc_pkg::tside_type tdiv_side;

   bsc_udiv_pipe #(
      .W  (bsc_pkg::WORD_W),
      .SW ($bits(bsc_pkg::tside_type))
   ) u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sb_vld_ff),
      .in_num    (sb_num_mag_ff),
      .in_den    (sb_den_mag_ff),
      .in_side   (sb_side_ff),
      .out_valid (tdiv_vld),
      .out_quo   (tdiv_quo),
      .out_side  (tdiv_side_raw)
   );

   assign tdiv_side = bsc_pkg::tside_type'(tdiv_side_raw);

   // Stage C: B5 = X1 + X2.
   logic [31:0] sc_b5_ff;
   logic        sc_err_ff;
   logic [18:0] sc_up_ff;
   logic [1:0]  sc_oss_ff;

   always_ff @(posedge clock) begin
      sc_b5_ff <= tdiv_side.x1 + (tdiv_side.neg ? 32'd0 - tdiv_quo : tdiv_quo);
      sc_err_ff <= tdiv_side.err;
      sc_up_ff <= tdiv_side.up;
      sc_oss_ff <= tdiv_side.oss;
   end

   // Stage D: temperature, B6 and B6 squared.
   logic [31:0] sd_b6;
   logic [31:0] sd_t_ff, sd_b6_ff, sd_sq_ff;
   logic        sd_err_ff;
   logic [18:0] sd_up_ff;
   logic [1:0]  sd_oss_ff;

   assign sd_b6 = sc_b5_ff - bsc_pkg::B6_OFFSET;

   always_ff @(posedge clock) begin
      sd_t_ff <= 32'($signed(sc_b5_ff + 32'd8) >>> 4);
      sd_b6_ff <= sd_b6;
      sd_sq_ff <= 32'(sd_b6 * sd_b6);
      sd_err_ff <= sc_err_ff;
      sd_up_ff <= sc_up_ff;
      sd_oss_ff <= sc_oss_ff;
   end

   // Stage E: the four calibration products.
   logic [31:0] se_sq;
   logic [31:0] se_pb2_ff, se_pac2_ff, se_pac3_ff, se_pb1_ff, se_t_ff;
   logic        se_err_ff;
   logic [18:0] se_up_ff;
   logic [1:0]  se_oss_ff;

   assign se_sq = 32'($signed(sd_sq_ff) >>> 12);

   always_ff @(posedge clock) begin
      se_pb2_ff <= 32'(cal.b2 * se_sq);
      se_pac2_ff <= 32'(cal.ac2 * sd_b6_ff);
      se_pac3_ff <= 32'(cal.ac3 * sd_b6_ff);
      se_pb1_ff <= 32'(cal.b1 * se_sq);
      se_t_ff <= sd_t_ff;
      se_err_ff <= sd_err_ff;
      se_up_ff <= sd_up_ff;
      se_oss_ff <= sd_oss_ff;
   end

   // Stage F: B3 and the scale term for B4.
   logic [31:0] sf_x3a, sf_b3_in, sf_x3b, sf_sum;
   logic [31:0] sf_b3_ff, sf_u_ff, sf_t_ff;
   logic        sf_err_ff;
   logic [18:0] sf_up_ff;
   logic [1:0]  sf_oss_ff;

   always_comb begin
      sf_x3a = 32'($signed(se_pb2_ff) >>> 11) + 32'($signed(se_pac2_ff) >>> 11);
      sf_sum = ((cal.ac1 << 2) + sf_x3a) << se_oss_ff;
      sf_b3_in = 32'($signed(sf_sum + 32'd2) >>> 2);
      sf_x3b = 32'($signed(se_pac3_ff) >>> 13) + 32'($signed(se_pb1_ff) >>> 16);
   end

   always_ff @(posedge clock) begin
      sf_b3_ff <= sf_b3_in;
      sf_u_ff <= 32'($signed(sf_x3b + 32'd2) >>> 2) + bsc_pkg::X3_BIAS;
      sf_t_ff <= se_t_ff;
      sf_err_ff <= se_err_ff;
      sf_up_ff <= se_up_ff;
      sf_oss_ff <= se_oss_ff;
   end

   // Stage G: raw B4 and B7 products.
   logic [31:0] sg_b4m_ff, sg_b7_ff, sg_t_ff;
   logic        sg_err_ff;

   always_ff @(posedge clock) begin
      sg_b4m_ff <= 32'(cal.ac4 * sf_u_ff);
      sg_b7_ff <= 32'(({13'd0, sf_up_ff} - sf_b3_ff) * (bsc_pkg::P_SCALE >> sf_oss_ff));
      sg_t_ff <= sf_t_ff;
      sg_err_ff <= sf_err_ff;
   end

   // Stage H: pressure divisor and dividend.
   logic [31:0] sh_b4;
   logic [31:0] sh_num_ff, sh_den_ff;
   bsc_pkg::pside_type sh_side_ff;

   assign sh_b4 = sg_b4m_ff >> 15;

   always_ff @(posedge clock) begin
      sh_den_ff <= sh_b4;
      sh_num_ff <= sg_b7_ff[31] ? sg_b7_ff : sg_b7_ff << 1;
      sh_side_ff.t <= sg_t_ff;
      sh_side_ff.err <= sg_err_ff || (sh_b4 == 32'd0);
      sh_side_ff.big <= sg_b7_ff[31];
   end

   // Pressure divider: (B7 << 1) / B4, or B7 / B4 when B7 has its top bit set.
   logic [31:0] pdiv_quo;
   logic [$bits(bsc_pkg::pside_type)-1:0] pdiv_side_raw;
   bsc_pkg::pside_type pdiv_side;

   bsc_udiv_pipe #(
      .W  (bsc_pkg::WORD_W),
      .SW ($bits(bsc_pkg::pside_type))
   ) u_pdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sh_vld_ff),
      .in_num    (sh_num_ff),
      .in_den    (sh_den_ff),
      .in_side   (sh_side_ff),
      .out_valid (pdiv_vld),
      .out_quo   (pdiv_quo),
      .out_side  (pdiv_side_raw)
   );

   assign pdiv_side = bsc_pkg::pside_type'(pdiv_side_raw);

   // Stage I: pressure squared and linear correction products.
   logic [31:0] si_p, si_pa;
   logic [31:0] si_p_ff, si_sq_ff, si_lin_ff, si_t_ff;
   logic        si_err_ff;

   always_comb begin
      si_p = pdiv_side.big ? pdiv_quo << 1 : pdiv_quo;
      si_pa = 32'($signed(si_p) >>> 8);
   end

   always_ff @(posedge clock) begin
      si_p_ff <= si_p;
      si_sq_ff <= 32'(si_pa * si_pa);
      si_lin_ff <= 32'(bsc_pkg::P_LIN_GAIN * si_p);
      si_t_ff <= pdiv_side.t;
      si_err_ff <= pdiv_side.err;
   end

   // Stage J: scaled square term and linear term.
   logic [31:0] sj_x1m_ff, sj_x2_ff, sj_p_ff, sj_t_ff;
   logic        sj_err_ff;

   always_ff @(posedge clock) begin
      sj_x1m_ff <= 32'(si_sq_ff * bsc_pkg::P_SQ_GAIN);
      sj_x2_ff <= 32'($signed(32'd0 - si_lin_ff) >>> 16);
      sj_p_ff <= si_p_ff;
      sj_t_ff <= si_t_ff;
      sj_err_ff <= si_err_ff;
   end

   // Stage K: final pressure, saturation and error masking.
   logic [31:0] sk_corr, sk_p;
   logic signed [31:0] sk_p_sat, sk_t_sat;
   logic [15:0] rsp_t_ff;
   logic [23:0] rsp_p_ff;
   logic        rsp_err_ff;

   always_comb begin
      sk_corr = 32'($signed(sj_x1m_ff) >>> 16) + sj_x2_ff + bsc_pkg::P_BIAS;
      sk_p = sj_p_ff + 32'($signed(sk_corr) >>> 4);
      priority if ($signed(sk_p) < bsc_pkg::P_MIN) begin
         sk_p_sat = bsc_pkg::P_MIN;
      end else if ($signed(sk_p) > bsc_pkg::P_MAX) begin
         sk_p_sat = bsc_pkg::P_MAX;
      end else begin
         sk_p_sat = $signed(sk_p);
      end
      priority if ($signed(sj_t_ff) < bsc_pkg::T_MIN) begin
         sk_t_sat = bsc_pkg::T_MIN;
      end else if ($signed(sj_t_ff) > bsc_pkg::T_MAX) begin
         sk_t_sat = bsc_pkg::T_MAX;
      end else begin
         sk_t_sat = $signed(sj_t_ff);
      end
   end

   always_ff @(posedge clock) begin
      rsp_t_ff <= sj_err_ff ? 16'd0 : sk_t_sat[15:0];
      rsp_p_ff <= sj_err_ff ? 24'd0 : sk_p_sat[23:0];
      rsp_err_ff <= sj_err_ff;
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         sa_vld_ff <= 1'b0;
         sb_vld_ff <= 1'b0;
         sc_vld_ff <= 1'b0;
         sd_vld_ff <= 1'b0;
         se_vld_ff <= 1'b0;
         sf_vld_ff <= 1'b0;
         sg_vld_ff <= 1'b0;
         sh_vld_ff <= 1'b0;
         si_vld_ff <= 1'b0;
         sj_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= accept;
         sa_vld_ff <= s0_vld_ff;
         sb_vld_ff <= sa_vld_ff;
         sc_vld_ff <= tdiv_vld;
         sd_vld_ff <= sc_vld_ff;
         se_vld_ff <= sd_vld_ff;
         sf_vld_ff <= se_vld_ff;
         sg_vld_ff <= sf_vld_ff;
         sh_vld_ff <= sg_vld_ff;
         si_vld_ff <= pdiv_vld;
         sj_vld_ff <= si_vld_ff;
         rsp_vld_ff <= sj_vld_ff;
      end
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_temperature_decidegrees = rsp_t_ff;
   assign rsp_pressure_pascal = rsp_p_ff;
   assign rsp_math_error = rsp_err_ff;

   // A flagged result carries zero values.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_math_error |->
         rsp_temperature_decidegrees == 16'd0 && rsp_pressure_pascal == 24'd0)
      else $error("math error result with nonzero values");

   // Every accepted transaction produces exactly one result after the fixed latency,
   // checked once the history reaches back past the end of reset.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      !$past(reset, LAT) |-> rsp_strobe == $past(accept, LAT))
      else $error("result strobe does not match request latency");

   // No result leaves the block right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule
